/* hw/rtl/kwl_pkg.sv */
`default_nettype none

package kwl_pkg;

	typedef enum logic [3:0] {
		K_END    = 4'd0,
		K_IDENT  = 4'd1,
		K_INT    = 4'd2,
		K_PLUS   = 4'd3,
		K_MINUS  = 4'd4,
		K_STAR   = 4'd5,
		K_SLASH  = 4'd6,
		K_LPAREN = 4'd7,
		K_RPAREN = 4'd8,
		K_VAR    = 4'd9,
		K_IF     = 4'd10,
		K_ELSE   = 4'd11,
		K_WHILE  = 4'd12,
		K_BAD    = 4'd13
	} kwl_kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE  = 4'b0001,
		MODE_INT   = 4'b0010,
		MODE_IDENT = 4'b0100,
		MODE_ERROR = 4'b1000
	} kwl_mode_t;

	typedef struct packed {
		kwl_kind_t   kind;
		logic [15:0] start;
		logic [7:0]  length;
		logic [7:0]  bad;
		logic        last;
	} kwl_token_t;

	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_UNDER  = 8'h5f;

	localparam logic [39:0] KW_VAR   = {16'h0000, "var"};
	localparam logic [39:0] KW_IF    = {24'h000000, "if"};
	localparam logic [39:0] KW_ELSE  = {8'h00, "else"};
	localparam logic [39:0] KW_WHILE = "while";

endpackage

`default_nettype wire

/* hw/rtl/keyword_lexer_byte_stream.sv */
// Keyword lexer over a byte stream.
// The item channel (item_valid/item_ready) carries one character in ch, or an
// end marker when end_of_input is set. The token channel (token_valid/token_ready)
// carries tokens: kind, start offset, length (both saturating), the offending
// byte for an invalid character, and last_of_run on the final token caused by
// an item. An item causes zero, one or two tokens.
// An accepted item lands in an input register and is lexed once the queue has
// room, which pushes its tokens into a four-entry output queue; the item passes
// the input register and then the queue before its first token is offered.
// One item is taken every cycle as long as the queue has room for two tokens.
// The queue drains one token per cycle while token_ready is high, so items that
// yield two tokens (a token closed by an operator, an invalid character or
// the end marker) take longer to drain. When the receiver stalls the queue fills
// and item_ready drops once fewer than two entries are free; nothing is lost.
// Reset clears the queue and returns the lexer to idle at offset zero. The end
// marker also returns it to that state after emitting the end token.
`default_nettype none

module keyword_lexer_byte_stream #(
	parameter int MAX_TOKEN_LENGTH  = 255,
	parameter int MAX_STRING_OFFSET = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [7:0]  ch,
	input  wire logic        end_of_input,
	output logic             token_valid,
	input  wire logic        token_ready,
	output logic [3:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [7:0]       token_length,
	output logic [7:0]       bad_char,
	output logic             last_of_run
);

	localparam int POS_W = $clog2(MAX_STRING_OFFSET + 1);
	localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
	localparam int SW    = (POS_W > 16) ? POS_W : 16;
	localparam int LW    = (LEN_W > 8) ? LEN_W : 8;
	localparam int QD    = 4;
	localparam int PTR_W = $clog2(QD);
	localparam int CNT_W = $clog2(QD + 1);

	function automatic logic [15:0] clamp_pos(input logic [POS_W-1:0] v);
		logic [SW-1:0] w;
		w = SW'(v);
		return (w > SW'(16'hffff)) ? 16'hffff : w[15:0];
	endfunction

	function automatic logic [7:0] clamp_len(input logic [LEN_W-1:0] v);
		logic [LW-1:0] w;
		w = LW'(v);
		return (w > LW'(8'hff)) ? 8'hff : w[7:0];
	endfunction

	logic                valid_s1;
	logic [7:0]          ch_s1;
	logic                eoi_s1;

	kwl_pkg::kwl_mode_t  mode_q, mode_d;
	logic [POS_W-1:0]    pos_q, pos_d, pos_inc;
	logic [POS_W-1:0]    tstart_q, tstart_d;
	logic [LEN_W-1:0]    tlen_q, tlen_d;
	logic [39:0]         prefix_q, prefix_d;

	kwl_pkg::kwl_token_t q_q [QD];
	logic [PTR_W-1:0]    wp_q, rp_q;
	logic [CNT_W-1:0]    count_q, count_d, avail;

	kwl_pkg::kwl_token_t tok_a, tok_b;
	logic                a_v, b_v;
	logic                pop, room, fire;
	logic                is_digit, is_alpha, is_space, has_close;
	kwl_pkg::kwl_kind_t  ident_kind, op_kind;

	assign pop   = token_valid && token_ready;
	assign avail = count_q - CNT_W'(pop);
	assign room  = avail <= CNT_W'(QD - 2);
	assign fire  = valid_s1 && room;
	assign item_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			ch_s1  <= ch;
			eoi_s1 <= end_of_input;
		end
	end

	assign is_digit  = ch_s1 inside {["0":"9"]};
	assign is_alpha  = ch_s1 inside {["a":"z"], ["A":"Z"]};
	assign is_space  = ch_s1 inside {8'd32, [8'd9:8'd13]};
	assign has_close = (mode_q == kwl_pkg::MODE_INT) || (mode_q == kwl_pkg::MODE_IDENT);
	assign pos_inc   = (pos_q < POS_W'(MAX_STRING_OFFSET)) ? pos_q + POS_W'(1) : pos_q;

	always_comb begin
		if (tlen_q == LEN_W'(3) && prefix_q == kwl_pkg::KW_VAR) begin
			ident_kind = kwl_pkg::K_VAR;
		end else if (tlen_q == LEN_W'(2) && prefix_q == kwl_pkg::KW_IF) begin
			ident_kind = kwl_pkg::K_IF;
		end else if (tlen_q == LEN_W'(4) && prefix_q == kwl_pkg::KW_ELSE) begin
			ident_kind = kwl_pkg::K_ELSE;
		end else if (tlen_q == LEN_W'(5) && prefix_q == kwl_pkg::KW_WHILE) begin
			ident_kind = kwl_pkg::K_WHILE;
		end else begin
			ident_kind = kwl_pkg::K_IDENT;
		end
	end

	always_comb begin
		case (ch_s1)
			kwl_pkg::CH_PLUS:   op_kind = kwl_pkg::K_PLUS;
			kwl_pkg::CH_MINUS:  op_kind = kwl_pkg::K_MINUS;
			kwl_pkg::CH_STAR:   op_kind = kwl_pkg::K_STAR;
			kwl_pkg::CH_SLASH:  op_kind = kwl_pkg::K_SLASH;
			kwl_pkg::CH_LPAREN: op_kind = kwl_pkg::K_LPAREN;
			kwl_pkg::CH_RPAREN: op_kind = kwl_pkg::K_RPAREN;
			default:            op_kind = kwl_pkg::K_BAD;
		endcase
	end

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		tstart_d = tstart_q;
		tlen_d   = tlen_q;
		prefix_d = prefix_q;
		a_v      = 1'b0;
		b_v      = 1'b0;

		// The token that the current item closes, if any.
		tok_a.kind   = (mode_q == kwl_pkg::MODE_INT) ? kwl_pkg::K_INT : ident_kind;
		tok_a.start  = clamp_pos(tstart_q);
		tok_a.length = clamp_len(tlen_q);
		tok_a.bad    = 8'h00;
		tok_a.last   = 1'b0;

		tok_b.kind   = op_kind;
		tok_b.start  = clamp_pos(pos_q);
		tok_b.length = 8'd1;
		tok_b.bad    = 8'h00;
		tok_b.last   = 1'b1;

		if (fire) begin
			if (eoi_s1) begin
				a_v          = has_close;
				b_v          = 1'b1;
				tok_b.kind   = kwl_pkg::K_END;
				tok_b.length = 8'd0;
				mode_d       = kwl_pkg::MODE_IDLE;
				pos_d        = '0;
				tstart_d     = '0;
				tlen_d       = '0;
				prefix_d     = '0;
			end else begin
				pos_d = pos_inc;
				if (mode_q == kwl_pkg::MODE_ERROR) begin
					mode_d = kwl_pkg::MODE_ERROR;
				end else if ((mode_q == kwl_pkg::MODE_INT && is_digit) ||
				             (mode_q == kwl_pkg::MODE_IDENT &&
				              (is_alpha || is_digit || ch_s1 == kwl_pkg::CH_UNDER))) begin
					// Only the first five bytes matter for keyword matching.
					if (tlen_q < LEN_W'(5)) begin
						prefix_d = {prefix_q[31:0], ch_s1};
					end
					if (tlen_q < LEN_W'(MAX_TOKEN_LENGTH)) begin
						tlen_d = tlen_q + LEN_W'(1);
					end
				end else begin
					a_v    = has_close;
					mode_d = kwl_pkg::MODE_IDLE;
					if (is_space) begin
						mode_d = kwl_pkg::MODE_IDLE;
					end else if (is_digit || is_alpha) begin
						mode_d   = is_digit ? kwl_pkg::MODE_INT : kwl_pkg::MODE_IDENT;
						tstart_d = pos_q;
						tlen_d   = LEN_W'(1);
						prefix_d = {32'h0, ch_s1};
					end else begin
						b_v = 1'b1;
						if (op_kind == kwl_pkg::K_BAD) begin
							tok_b.bad = ch_s1;
							mode_d    = kwl_pkg::MODE_ERROR;
						end
					end
				end
			end
		end

		if (!b_v) begin
			tok_a.last = 1'b1;
		end
	end

	assign count_d = count_q + CNT_W'(a_v) + CNT_W'(b_v) - CNT_W'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= kwl_pkg::MODE_IDLE;
			pos_q    <= '0;
			tstart_q <= '0;
			tlen_q   <= '0;
			prefix_q <= '0;
			wp_q     <= '0;
			rp_q     <= '0;
			count_q  <= '0;
		end else begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			tstart_q <= tstart_d;
			tlen_q   <= tlen_d;
			prefix_q <= prefix_d;
			count_q  <= count_d;
			wp_q     <= wp_q + PTR_W'(a_v) + PTR_W'(b_v);
			if (pop) begin
				rp_q <= rp_q + PTR_W'(1);
			end
		end
	end

	// A closed token goes first; an operator, bad-character or end token follows it.
	always_ff @(posedge clk) begin
		if (a_v) begin
			q_q[wp_q] <= tok_a;
			if (b_v) begin
				q_q[wp_q + PTR_W'(1)] <= tok_b;
			end
		end else if (b_v) begin
			q_q[wp_q] <= tok_b;
		end
	end

	assign token_valid  = count_q != '0;
	assign token_kind   = q_q[rp_q].kind;
	assign token_start  = q_q[rp_q].start;
	assign token_length = q_q[rp_q].length;
	assign bad_char     = q_q[rp_q].bad;
	assign last_of_run  = q_q[rp_q].last;

endmodule

`default_nettype wire

/* hw/rtl/kwl_checker.sv */
`default_nettype none

module kwl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        token_valid,
	input wire logic        token_ready,
	input wire logic [3:0]  token_kind,
	input wire logic [15:0] token_start,
	input wire logic [7:0]  token_length,
	input wire logic [7:0]  bad_char,
	input wire logic        last_of_run
);

	// A stalled token transaction keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> token_valid && $stable(token_kind) &&
		$stable(token_start) && $stable(token_length) && $stable(bad_char) &&
		$stable(last_of_run))
		else $error("token payload changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind != kwl_pkg::K_BAD |-> bad_char == 8'h00)
		else $error("bad_char set on a valid token");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == kwl_pkg::K_END |-> last_of_run && token_length == 8'd0)
		else $error("end token is not the last of its run or has a length");

	// Single-character tokens always report a length of one.
	a_single_len: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_kind == kwl_pkg::K_PLUS || token_kind == kwl_pkg::K_MINUS ||
		token_kind == kwl_pkg::K_STAR || token_kind == kwl_pkg::K_SLASH ||
		token_kind == kwl_pkg::K_LPAREN || token_kind == kwl_pkg::K_RPAREN ||
		token_kind == kwl_pkg::K_BAD) |-> token_length == 8'd1 && last_of_run)
		else $error("single-character token with wrong length or not last");

endmodule

bind keyword_lexer_byte_stream kwl_checker u_kwl_checker (.*);

`default_nettype wire
